// ===== design/hex_frame_decoder_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the hex frame decoder
// Both macros sample on the rising edge of clock and are held off in reset.
// ---------------------------------------------------------------------------
`ifndef HEX_FRAME_DECODER_ASSERT_SVH
`define HEX_FRAME_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HFD_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hex frame decoder: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define HFD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hex frame decoder: next-cycle check failed");

`endif

// ===== design/hfd_pkg.sv =====
// ---------------------------------------------------------------------------
// hfd_pkg
// Types, character codes and status codes shared by the hex frame decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hfd_pkg;

   // Default payload byte limit per frame
   localparam int MAX_DATA_DEFAULT = 32;

   // Result queue: depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int FILL_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Frame constants
   localparam logic [7:0] SUM_TARGET   = 8'h55;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   // Result kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Frame status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NO_COLON  = 3'd1;
   localparam logic [2:0] STATUS_TOO_SHORT = 3'd2;
   localparam logic [2:0] STATUS_BAD_CHAR  = 3'd3;
   localparam logic [2:0] STATUS_ODD_LEN   = 3'd4;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd5;
   localparam logic [2:0] STATUS_BAD_SUM   = 3'd6;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_frame;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [4:0] data_index;
      logic [2:0] status;
      logic [3:0] command;
      logic [5:0] data_length;
      logic       last;
   } rsp_type;

   // Up to two results produced by one character beat
   typedef struct packed {
      logic    data_valid;
      rsp_type data_res;
      logic    status_valid;
      rsp_type status_res;
   } push_type;

endpackage

// ===== design/hfd_core.sv =====
// ---------------------------------------------------------------------------
// hfd_core
// Frame state registers and the per-character decode: nibble decode, byte
// assembly, checksum add and frame judgement on the final character.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfd_core #(
   parameter int MaxData = hfd_pkg::MAX_DATA_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              beat_accept,
   input  hfd_pkg::req_type  req_beat,
   output hfd_pkg::push_type push
);
   import hfd_pkg::*;

   localparam logic [5:0] MAX_LIMIT    = 6'(MaxData);
   localparam logic [5:0] MAX_LIMIT_P1 = 6'(MaxData + 1);
   localparam logic [6:0] COUNT_SAT    = 7'd127;
   localparam logic [5:0] BYTES_SAT    = 6'd63;
   localparam logic [6:0] MIN_CHARS    = 7'd4;

   logic [6:0] char_count_ff,    char_count_in;
   logic       length_odd_ff,    length_odd_in;
   logic       colon_seen_ff,    colon_seen_in;
   logic       bad_seen_ff,      bad_seen_in;
   logic [3:0] command_ff,       command_in;
   logic [3:0] high_nibble_ff,   high_nibble_in;
   logic [7:0] sum_ff,           sum_in;
   logic [7:0] pending_byte_ff,  pending_byte_in;
   logic       pending_valid_ff, pending_valid_in;
   logic [5:0] bytes_done_ff,    bytes_done_in;

   logic       is_digit;
   logic       is_upper;
   logic [3:0] nibble;
   logic       first_char;
   logic       command_char;
   logic       byte_char;
   logic [7:0] new_byte;
   logic [5:0] index_full;
   logic [2:0] frame_status;
   logic [5:0] frame_length;

   // Decode one uppercase hex digit; anything else reads as zero
   assign is_digit = (req_beat.char_in >= CHAR_ZERO) && (req_beat.char_in <= CHAR_NINE);
   assign is_upper = (req_beat.char_in >= CHAR_UPPER_A) && (req_beat.char_in <= CHAR_UPPER_F);

   always_comb begin
      priority if (is_digit) begin
         nibble = 4'(req_beat.char_in - CHAR_ZERO);
      end else if (is_upper) begin
         nibble = 4'(req_beat.char_in - (CHAR_UPPER_A - 8'd10));
      end else begin
         nibble = 4'd0;
      end
   end

   assign first_char   = (char_count_ff == 7'd0);
   assign command_char = (char_count_ff == 7'd1);
   assign byte_char    = !first_char && !command_char && length_odd_ff;
   assign new_byte     = {high_nibble_ff, nibble};

   // Advance the frame state for this character
   always_comb begin
      colon_seen_in    = colon_seen_ff;
      bad_seen_in      = bad_seen_ff;
      command_in       = command_ff;
      high_nibble_in   = high_nibble_ff;
      sum_in           = sum_ff;
      pending_byte_in  = pending_byte_ff;
      pending_valid_in = pending_valid_ff;
      bytes_done_in    = bytes_done_ff;
      if (first_char) begin
         colon_seen_in = (req_beat.char_in == CHAR_COLON);
      end else begin
         if (!(is_digit || is_upper)) begin
            bad_seen_in = 1'b1;
         end
         priority if (command_char) begin
            command_in = nibble;
            sum_in     = sum_ff + {4'd0, nibble};
         end else if (!length_odd_ff) begin
            high_nibble_in = nibble;
         end else begin
            sum_in           = sum_ff + new_byte;
            pending_byte_in  = new_byte;
            pending_valid_in = 1'b1;
            if (bytes_done_ff != BYTES_SAT) begin
               bytes_done_in = bytes_done_ff + 6'd1;
            end
         end
      end
      char_count_in = (char_count_ff == COUNT_SAT) ? COUNT_SAT : char_count_ff + 7'd1;
      length_odd_in = ~length_odd_ff;
   end

   // Judge the frame from the state as it stands after this character
   always_comb begin
      frame_length = 6'd0;
      priority if (!colon_seen_in) begin
         frame_status = STATUS_NO_COLON;
      end else if (char_count_in < MIN_CHARS) begin
         frame_status = STATUS_TOO_SHORT;
      end else if (bad_seen_in) begin
         frame_status = STATUS_BAD_CHAR;
      end else if (length_odd_in) begin
         frame_status = STATUS_ODD_LEN;
      end else if ((bytes_done_in == 6'd0) || (bytes_done_in > MAX_LIMIT_P1)) begin
         frame_status = STATUS_TOO_LONG;
      end else if (sum_in != SUM_TARGET) begin
         frame_status = STATUS_BAD_SUM;
      end else begin
         frame_status = STATUS_OK;
         frame_length = bytes_done_in - 6'd1;
      end
   end

   // Release the previously completed byte as a data result
   assign index_full = bytes_done_ff - 6'd1;

   always_comb begin
      push.data_valid = beat_accept && byte_char && pending_valid_ff &&
                        (bytes_done_ff <= MAX_LIMIT);
      push.data_res.kind        = KIND_DATA;
      push.data_res.data_byte   = pending_byte_ff;
      push.data_res.data_index  = index_full[4:0];
      push.data_res.status      = STATUS_OK;
      push.data_res.command     = command_in;
      push.data_res.data_length = 6'd0;
      push.data_res.last        = !req_beat.end_of_frame;

      push.status_valid = beat_accept && req_beat.end_of_frame;
      push.status_res.kind        = KIND_STATUS;
      push.status_res.data_byte   = 8'd0;
      push.status_res.data_index  = 5'd0;
      push.status_res.status      = frame_status;
      push.status_res.command     = command_in;
      push.status_res.data_length = frame_length;
      push.status_res.last        = 1'b1;
   end

   // Hold state between beats; clear on reset and after the final character
   always_ff @(posedge clock) begin
      if (reset || (beat_accept && req_beat.end_of_frame)) begin
         char_count_ff    <= '0;
         length_odd_ff    <= 1'b0;
         colon_seen_ff    <= 1'b0;
         bad_seen_ff      <= 1'b0;
         command_ff       <= '0;
         high_nibble_ff   <= '0;
         sum_ff           <= '0;
         pending_byte_ff  <= '0;
         pending_valid_ff <= 1'b0;
         bytes_done_ff    <= '0;
      end else if (beat_accept) begin
         char_count_ff    <= char_count_in;
         length_odd_ff    <= length_odd_in;
         colon_seen_ff    <= colon_seen_in;
         bad_seen_ff      <= bad_seen_in;
         command_ff       <= command_in;
         high_nibble_ff   <= high_nibble_in;
         sum_ff           <= sum_in;
         pending_byte_ff  <= pending_byte_in;
         pending_valid_ff <= pending_valid_in;
         bytes_done_ff    <= bytes_done_in;
      end
   end

endmodule

// ===== design/hfd_queue.sv =====
// ---------------------------------------------------------------------------
// hfd_queue
// Small result queue: takes up to two results per cycle, hands out one beat
// per cycle on the result channel while rsp_stall is low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfd_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  hfd_pkg::push_type               push,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output hfd_pkg::rsp_type                rsp_payload,
   output logic [hfd_pkg::FILL_WIDTH-1:0]  fill_count
);
   import hfd_pkg::*;

   rsp_type               entries_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_WIDTH-1:0] fill_ff,   fill_in;

   logic                  first_valid;
   logic                  second_valid;
   rsp_type               first_res;
   logic [FILL_WIDTH-1:0] push_count;
   logic                  pop;

   // Pack the results of one beat into consecutive slots
   assign first_valid  = push.data_valid || push.status_valid;
   assign second_valid = push.data_valid && push.status_valid;
   assign first_res    = push.data_valid ? push.data_res : push.status_res;
   assign push_count   = FILL_WIDTH'(first_valid) + FILL_WIDTH'(second_valid);
   assign pop          = rsp_valid && !rsp_stall;

   assign wr_ptr_in = wr_ptr_ff + PTR_WIDTH'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_WIDTH'(pop);
   assign fill_in   = fill_ff + push_count - FILL_WIDTH'(pop);

   // Write slots
   always_ff @(posedge clock) begin
      if (first_valid) begin
         entries_ff[wr_ptr_ff] <= first_res;
      end
      if (second_valid) begin
         entries_ff[wr_ptr_ff + PTR_WIDTH'(1)] <= push.status_res;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   assign rsp_valid   = (fill_ff != '0);
   assign rsp_payload = entries_ff[rd_ptr_ff];
   assign fill_count  = fill_ff;

endmodule

// ===== design/hex_frame_decoder.sv =====
// ---------------------------------------------------------------------------
// hex_frame_decoder
// Streaming decoder for colon-led uppercase hex frames, one character a beat.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  req_payload (char, end flag)
//   rsp_     out        rsp_valid / rsp_stall  rsp_payload (data or status)
//
// One character is taken per cycle while req_stall is low; decode, checksum add
// and frame judgement are done in the cycle the beat is accepted, and results
// are registered into a four-entry result queue.
// A character that finishes a frame and also releases a data byte yields two
// results, which leave the queue one after the other; that queue's single read
// port sets the output rate at one result per cycle while rsp_stall is low.
// req_stall rises while the queue has room for fewer than two results.
// Reset is synchronous and clears the frame state and the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_frame_decoder #(
   parameter int MAX_DATA = hfd_pkg::MAX_DATA_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hfd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hfd_pkg::rsp_type rsp_payload
);
   import hfd_pkg::*;

`include "hex_frame_decoder_assert.svh"

   localparam logic [5:0] MAX_LIMIT = 6'(MAX_DATA);

   push_type              push;
   logic                  beat_accept;
   logic [FILL_WIDTH-1:0] fill_count;
   logic                  ok_status_beat;

   // Stall input while a two-result beat might not fit
   assign req_stall   = (fill_count > FILL_WIDTH'(QUEUE_DEPTH - 2));
   assign beat_accept = req_valid && !req_stall;

   hfd_core #(
      .MaxData (MAX_DATA)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .req_beat    (req_payload),
      .push        (push)
   );

   hfd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fill_count  (fill_count)
   );

   // Flag a good-frame status on the output
   assign ok_status_beat = rsp_valid && (rsp_payload.kind == KIND_STATUS) &&
                           (rsp_payload.status == STATUS_OK);

   // Queue never overfills
   `HFD_ASSERT_SAME(a_fill_bound, 1'b1, fill_count <= FILL_WIDTH'(QUEUE_DEPTH))

   // A frame judged good never reports more bytes than the limit
   `HFD_ASSERT_SAME(a_ok_length, ok_status_beat, rsp_payload.data_length <= MAX_LIMIT)

   // A finished frame always leaves the result output valid in the next cycle
   `HFD_ASSERT_NEXT(a_eof_status, beat_accept && req_payload.end_of_frame, rsp_valid)

   // Results are pushed only on an accepted beat
   `HFD_ASSERT_SAME(a_push_gated, push.data_valid || push.status_valid, beat_accept)

endmodule
